// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker of the PID block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Clocked property that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/pidpi_pkg.sv -----
// Package of the PID controller: widths, mode and register codes, stage types.
// Depends on nothing; imported by every module of the block.
package pidpi_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int INTEGRAL_WIDTH = 32;

    localparam int REG_W   = 16;                     // setpoint and gains
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // error, history operand and integral widths
    localparam int ERR_W = SAMPLE_WIDTH + 1;
    localparam int OPP_W = ERR_W + 2;
    localparam int OPI_W = (INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W;
    localparam int PP_W  = REG_W + OPP_W;
    localparam int PI_W  = REG_W + OPI_W;
    localparam int ACC_W = ((PI_W > PP_W) ? PI_W : PP_W) + 2;

    // mode codes; the unused code runs as incremental
    localparam logic [MODE_W-1:0] MODE_POS_SP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS_ERR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INCR    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd5;

    // multiplier operands handed from the error stage
    typedef struct packed {
        logic signed [OPP_W-1:0] op_p;
        logic signed [OPI_W-1:0] op_i;
        logic signed [OPP_W-1:0] op_d;
    } t_ops;

endpackage

// ----- rtl/pidpi_err_stage.sv -----
// Error stage of the PID controller: forms the error, keeps the error history
// and the saturating integral, and registers the three multiplier operands.
// Depends on pidpi_pkg.
module pidpi_err_stage
    import pidpi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic signed [REG_W-1:0] i_setpoint,
    input  logic                    i_adv,
    output logic                    o_valid,
    output t_ops                    o_ops
);

    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX =
        {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN =
        {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    logic                             r_valid;
    t_ops                             r_ops;
    logic signed [INTEGRAL_WIDTH-1:0] r_err_sum;
    logic signed [ERR_W-1:0]          r_last_err;
    logic signed [ERR_W-1:0]          r_prior_err;

    logic                             accept;
    logic                             positional;
    logic signed [ERR_W-1:0]          err;
    logic signed [INTEGRAL_WIDTH:0]   sum_wide;
    logic signed [INTEGRAL_WIDTH-1:0] n_err_sum;
    t_ops                             n_ops;

    assign o_ready = !r_valid || i_adv;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_ops   = r_ops;

    // error and integral with saturation
    always_comb begin
        positional = (i_mode == MODE_POS_SP) || (i_mode == MODE_POS_ERR);
        if (i_mode == MODE_POS_ERR) begin
            err = ERR_W'(i_sample);
        end else begin
            err = ERR_W'(i_setpoint) - ERR_W'(i_sample);
        end
        sum_wide = (INTEGRAL_WIDTH+1)'(r_err_sum) + (INTEGRAL_WIDTH+1)'(err);
        if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1]) begin
            n_err_sum = sum_wide[INTEGRAL_WIDTH] ? INT_MIN : INT_MAX;
        end else begin
            n_err_sum = sum_wide[INTEGRAL_WIDTH-1:0];
        end
    end

    // operand selection per variant
    always_comb begin
        if (positional) begin
            n_ops.op_p = OPP_W'(err);
            n_ops.op_i = OPI_W'(n_err_sum);
            n_ops.op_d = OPP_W'(r_last_err) - OPP_W'(r_prior_err);
        end else begin
            n_ops.op_p = OPP_W'(err) - OPP_W'(r_last_err);
            n_ops.op_i = OPI_W'(err);
            n_ops.op_d = OPP_W'(err) - (OPP_W'(r_last_err) <<< 1) + OPP_W'(r_prior_err);
        end
    end

    // request valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum   <= '0;
            r_last_err  <= '0;
            r_prior_err <= '0;
        end else if (accept) begin
            if (positional) begin
                r_err_sum <= n_err_sum;
            end
            r_prior_err <= r_last_err;
            r_last_err  <= err;
        end
    end

    // operand register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ops <= n_ops;
        end
    end

endmodule

// ----- rtl/pid_position_incremental_controller_unit.sv -----
// PID controller, positional and incremental. Three register stages (error,
// multiplier, sum and clamp) lie between the accepted request and the drive.
// Throughput one request per cycle; each stage holds while the next is full.
// Synchronous active-low reset clears configuration registers, valid flags, error history and integral.
// Depends on pidpi_pkg and pidpi_err_stage.
module pid_position_incremental_controller_unit
    import pidpi_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [DRIVE_W-1:0]      o_drive
);

    logic [MODE_W-1:0]        r_mode;
    logic signed [REG_W-1:0]  r_setpoint;
    logic [LIMIT_W-1:0]       r_limit;
    logic signed [REG_W-1:0]  r_gain_p;
    logic signed [REG_W-1:0]  r_gain_i;
    logic signed [REG_W-1:0]  r_gain_d;

    logic                     v1;
    t_ops                     ops;
    logic                     rdy2;
    logic                     rdy3;

    logic                     r_v2;
    logic signed [PP_W-1:0]   r_prod_p;
    logic signed [PI_W-1:0]   r_prod_i;
    logic signed [PP_W-1:0]   r_prod_d;

    logic                     r_v3;
    logic signed [DRIVE_W-1:0] r_drive;

    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lim;
    logic signed [ACC_W-1:0]  n_drive;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_POS_SP;
            r_setpoint <= '0;
            r_limit    <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:     r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_SETPOINT: r_setpoint <= REG_W'(i_cfg_data);
                CFG_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_GAIN_P:   r_gain_p   <= REG_W'(i_cfg_data);
                CFG_GAIN_I:   r_gain_i   <= REG_W'(i_cfg_data);
                CFG_GAIN_D:   r_gain_d   <= REG_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage 1: error, history and integral
    pidpi_err_stage u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_mode     (r_mode),
        .i_setpoint (r_setpoint),
        .i_adv      (rdy2),
        .o_valid    (v1),
        .o_ops      (ops)
    );

    assign rdy3 = !r_v3 || i_ready;
    assign rdy2 = !r_v2 || rdy3;

    // stage 2: gain products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && v1) begin
            r_prod_p <= PP_W'(r_gain_p) * PP_W'(ops.op_p);
            r_prod_i <= PI_W'(r_gain_i) * PI_W'(ops.op_i);
            r_prod_d <= PP_W'(r_gain_d) * PP_W'(ops.op_d);
        end
    end

    // stage 3: sum and symmetric clamp
    always_comb begin
        acc = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        lim = ACC_W'({1'b0, r_limit});
        if (acc > lim) begin
            n_drive = lim;
        end else if (acc < -lim) begin
            n_drive = -lim;
        end else begin
            n_drive = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_drive <= n_drive[DRIVE_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_drive = r_drive;

endmodule

// ----- rtl/pidpi_checker.sv -----
// Port-level checks for the PID controller, bound to its top level.
// Depends on pidpi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pidpi_checker
    import pidpi_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [DRIVE_W-1:0] o_drive
);

    // a stalled result stays valid and unchanged
    `ASSERT_CLK(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `ASSERT_CLK(a_hold_drive, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_drive))

    // clamp is symmetric, so the most negative code never shows
    `ASSERT_CLK(a_drive_range, i_clk, i_rst_n, o_valid |-> o_drive != 16'sh8000)

    // an empty output stage lets the whole pipe take a request
    `ASSERT_CLK(a_ready_empty, i_clk, i_rst_n, !o_valid |-> o_ready)

    // reset flushes the pipe
    `ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind pid_position_incremental_controller_unit pidpi_checker u_pidpi_checker (.*);
